// File: src/lsbt_pkg.sv
// Shared types and constants for the line-of-sight block test.
`timescale 1ns / 1ps

package lsbt_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CfgIdxW = 2;
  localparam int CountW = 7;
  localparam int SlotW  = 6;

  localparam logic [CfgIdxW-1:0] REG_BASE_X     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE_Y     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WALL_COUNT = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [SlotW-1:0]         wall_index;
    logic signed [CoordW-1:0] end_a_x;
    logic signed [CoordW-1:0] end_a_y;
    logic signed [CoordW-1:0] end_b_x;
    logic signed [CoordW-1:0] end_b_y;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic              blocked;
    logic [CountW-1:0] wall_number;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
  } wall_t;

  // cross product p*s - q*r
  typedef struct packed {
    logic signed [DiffW-1:0] p;
    logic signed [DiffW-1:0] q;
    logic signed [DiffW-1:0] r;
    logic signed [DiffW-1:0] s;
  } xp_op_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } xp_sign_t;

endpackage

// File: src/lsbt_wall_mem.sv
// Wall segment table, one write port and one registered read port.
`timescale 1ns / 1ps

module lsbt_wall_mem #(
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  lsbt_pkg::wall_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output lsbt_pkg::wall_t      rd_data_o
);

  lsbt_pkg::wall_t mem_q [Depth];
  lsbt_pkg::wall_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/lsbt_cross_unit.sv
// Pipelined cross product unit returning the sign of p*s - q*r.
`timescale 1ns / 1ps

module lsbt_cross_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lsbt_pkg::xp_op_t   op_i,
  output logic               valid_o,
  output lsbt_pkg::xp_sign_t sign_o
);

  lsbt_pkg::xp_op_t                   op_q;
  logic signed [lsbt_pkg::ProdW-1:0]  prod_ps_q;
  logic signed [lsbt_pkg::ProdW-1:0]  prod_qr_q;
  lsbt_pkg::xp_sign_t                 sign_q;
  logic                               v_op_q;
  logic                               v_prod_q;
  logic                               v_sign_q;
  logic signed [lsbt_pkg::ProdW:0]    diff;

  assign diff = {prod_ps_q[lsbt_pkg::ProdW-1], prod_ps_q}
              - {prod_qr_q[lsbt_pkg::ProdW-1], prod_qr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_op_q   <= 1'b0;
      v_prod_q <= 1'b0;
      v_sign_q <= 1'b0;
    end else begin
      v_op_q   <= valid_i;
      v_prod_q <= v_op_q;
      v_sign_q <= v_prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_i;
    prod_ps_q <= op_q.p * op_q.s;
    prod_qr_q <= op_q.q * op_q.r;
    sign_q    <= '{zero: (diff == '0), neg: diff[lsbt_pkg::ProdW]};
  end

  assign valid_o = v_sign_q;
  assign sign_o  = sign_q;

endmodule

// File: src/line_of_sight_block_test.sv
// Top level: configuration, wall table, query sequencer and result register.
// Load: accepted while idle, writes one table slot if its index is below MAX_WALLS, gives no result.
// Query: per wall scanned, one table read, five products through the
//   three-stage cross product unit, and one decision; stops at the first hit.
//   One item at a time: no new item is accepted until the result is registered.
// Reset clears control state, configuration and output registers; the wall table is not cleared.
`timescale 1ns / 1ps

module line_of_sight_block_test #(
  parameter int MAX_WALLS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lsbt_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lsbt_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lsbt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lsbt_pkg::CoordW-1:0]       cfg_data_i
);

  localparam int AddrW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int NumXp = 5;
  localparam logic [2:0] XP_PAR = 3'd0;
  localparam logic [2:0] XP_O1  = 3'd1;
  localparam logic [2:0] XP_O2  = 3'd2;
  localparam logic [2:0] XP_O3  = 3'd3;
  localparam logic [2:0] XP_O4  = 3'd4;
  localparam logic [2:0] XP_END = 3'(NumXp);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DECIDE,
    S_DONE
  } state_e;

  function automatic logic signed [lsbt_pkg::DiffW-1:0] sub17(
    input logic signed [lsbt_pkg::CoordW-1:0] a,
    input logic signed [lsbt_pkg::CoordW-1:0] b
  );
    return {a[lsbt_pkg::CoordW-1], a} - {b[lsbt_pkg::CoordW-1], b};
  endfunction

  function automatic logic opposite(input lsbt_pkg::xp_sign_t a,
                                    input lsbt_pkg::xp_sign_t b);
    return a.zero | b.zero | (a.neg ^ b.neg);
  endfunction

  logic signed [lsbt_pkg::CoordW-1:0] base_x_q;
  logic signed [lsbt_pkg::CoordW-1:0] base_y_q;
  logic [lsbt_pkg::CountW-1:0]        wall_count_q;

  state_e                             state_q;
  logic signed [lsbt_pkg::CoordW-1:0] pt_x_q;
  logic signed [lsbt_pkg::CoordW-1:0] pt_y_q;
  logic [lsbt_pkg::CountW-1:0]        n_q;
  logic [lsbt_pkg::CountW-1:0]        wall_q;
  logic [2:0]                         iss_q;
  logic [2:0]                         col_q;
  lsbt_pkg::xp_sign_t                 sgn_q [NumXp];
  logic                               hit_q;
  logic                               out_valid_q;
  lsbt_pkg::out_item_t                out_data_q;

  logic                               in_xfer;
  logic                               out_xfer;
  logic                               slot_ok;
  logic [lsbt_pkg::CountW-1:0]        n_clip;
  logic                               hit;
  lsbt_pkg::wall_t                    wr_wall;
  lsbt_pkg::wall_t                    rd_wall;
  lsbt_pkg::xp_op_t                   xp_op;
  logic                               xp_issue;
  logic                               xp_valid;
  lsbt_pkg::xp_sign_t                 xp_sign;
  logic signed [lsbt_pkg::DiffW-1:0]  dux;
  logic signed [lsbt_pkg::DiffW-1:0]  duy;
  logic signed [lsbt_pkg::DiffW-1:0]  dwx;
  logic signed [lsbt_pkg::DiffW-1:0]  dwy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q     <= '0;
      base_y_q     <= '0;
      wall_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lsbt_pkg::REG_BASE_X:     base_x_q     <= cfg_data_i;
        lsbt_pkg::REG_BASE_Y:     base_y_q     <= cfg_data_i;
        lsbt_pkg::REG_WALL_COUNT: wall_count_q <= cfg_data_i[lsbt_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_xfer    = out_valid_q & out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign slot_ok = (32'(in_data_i.wall_index) < MAX_WALLS);
  assign n_clip  = (32'(wall_count_q) > MAX_WALLS) ? lsbt_pkg::CountW'(MAX_WALLS)
                                                   : wall_count_q;

  assign wr_wall = '{ax: in_data_i.end_a_x, ay: in_data_i.end_a_y,
                     bx: in_data_i.end_b_x, by: in_data_i.end_b_y};

  lsbt_wall_mem #(
    .Depth (MAX_WALLS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_xfer && (in_data_i.action == lsbt_pkg::ACT_LOAD) && slot_ok),
    .wr_addr_i (AddrW'(32'(in_data_i.wall_index))),
    .wr_data_i (wr_wall),
    .rd_en_i   (state_q == S_READ),
    .rd_addr_i (AddrW'(32'(wall_q))),
    .rd_data_o (rd_wall)
  );

  assign dux = sub17(pt_x_q, base_x_q);
  assign duy = sub17(pt_y_q, base_y_q);
  assign dwx = sub17(rd_wall.bx, rd_wall.ax);
  assign dwy = sub17(rd_wall.by, rd_wall.ay);

  always_comb begin
    case (iss_q)
      XP_PAR:  xp_op = '{p: dux, q: duy, r: dwx, s: dwy};
      XP_O1:   xp_op = '{p: dux, q: duy, r: sub17(rd_wall.ax, base_x_q),
                         s: sub17(rd_wall.ay, base_y_q)};
      XP_O2:   xp_op = '{p: dux, q: duy, r: sub17(rd_wall.bx, base_x_q),
                         s: sub17(rd_wall.by, base_y_q)};
      XP_O3:   xp_op = '{p: dwx, q: dwy, r: sub17(base_x_q, rd_wall.ax),
                         s: sub17(base_y_q, rd_wall.ay)};
      XP_O4:   xp_op = '{p: dwx, q: dwy, r: sub17(pt_x_q, rd_wall.ax),
                         s: sub17(pt_y_q, rd_wall.ay)};
      default: xp_op = '0;
    endcase
  end

  assign xp_issue = (state_q == S_CALC) && (iss_q < XP_END);

  lsbt_cross_unit u_xp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (xp_issue),
    .op_i    (xp_op),
    .valid_o (xp_valid),
    .sign_o  (xp_sign)
  );

  assign hit = !sgn_q[XP_PAR].zero
             & opposite(sgn_q[XP_O1], sgn_q[XP_O2])
             & opposite(sgn_q[XP_O3], sgn_q[XP_O4]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pt_x_q      <= '0;
      pt_y_q      <= '0;
      n_q         <= '0;
      wall_q      <= '0;
      iss_q       <= '0;
      col_q       <= '0;
      sgn_q       <= '{default: '0};
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_xfer && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer && (in_data_i.action == lsbt_pkg::ACT_QUERY)) begin
            pt_x_q <= in_data_i.point_x;
            pt_y_q <= in_data_i.point_y;
            n_q    <= n_clip;
            wall_q <= '0;
            hit_q  <= 1'b0;
            state_q <= (n_clip == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          iss_q   <= '0;
          col_q   <= '0;
          state_q <= S_CALC;
        end
        S_CALC: begin
          if (xp_issue) begin
            iss_q <= iss_q + 3'd1;
          end
          if (xp_valid) begin
            sgn_q[col_q] <= xp_sign;
            col_q        <= col_q + 3'd1;
            if (col_q == XP_END - 3'd1) begin
              state_q <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (hit) begin
            hit_q   <= 1'b1;
            state_q <= S_DONE;
          end else if (wall_q + lsbt_pkg::CountW'(1) == n_q) begin
            state_q <= S_DONE;
          end else begin
            wall_q  <= wall_q + lsbt_pkg::CountW'(1);
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '{blocked: hit_q,
                             wall_number: hit_q ? wall_q + lsbt_pkg::CountW'(1) : '0};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.blocked == (out_data_o.wall_number != '0)))
    else $error("blocked flag disagrees with wall number");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (wall_q < n_q))
    else $error("wall read beyond active count");

  a_xp_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xp_valid |-> (state_q == S_CALC))
    else $error("cross product result outside calculation");

  a_empty_query_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_data_i.action == lsbt_pkg::ACT_QUERY) && (wall_count_q == '0))
      |=> (state_q == S_DONE))
    else $error("query with no walls did not finish at once");

endmodule
